[hdl/rzs_pkg.sv]
// rzs_pkg: shared constants and types for the rolling z-score block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rzs_pkg;
    localparam int SYMBOL_COUNT_DEF = 16;
    localparam int WINDOW_MAX_DEF   = 64;
    localparam logic [6:0] WINDOW_LENGTH_RESET = 7'd20;
    localparam int PRICE_W = 32;
    localparam int Z_W     = 20;
    localparam int SYM_W   = 4;
    localparam int LEN_W   = 7;

    // request from sequencer to arithmetic unit
    typedef struct packed {
        logic [95:0] num;   // L*sum(d^2) - r^2, always >= 0
        logic [20:0] den;   // L*L
    } rzs_var_req_t;
endpackage
`default_nettype wire

[hdl/rzs_ram.sv]
// rzs_ram: generic single-port-write, one-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rzs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[hdl/rzs_div.sv]
// rzs_div: restoring divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module rzs_div #(
    parameter int NW = 96,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   shifted;
    logic [DW+1:0] diff;

    assign shifted = {rem_reg[DW-1:0], q_reg[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b0, d_reg};
    assign quo     = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            d_reg   <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

[hdl/rzs_sqrt.sv]
// rzs_sqrt: bit-pair integer square root, one result bit per cycle
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module rzs_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             done,
    output logic      [31:0] root
);
    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] r_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [33:0] trial_rem;
    logic [33:0] trial;
    logic [34:0] diff;

    assign trial_rem = {rem_reg[31:0], x_reg[63:62]};
    assign trial     = {r_reg, 2'b01};
    assign diff      = {1'b0, trial_rem} - {1'b0, trial};
    assign root      = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            rem_reg <= '0;
            r_reg   <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[61:0], 2'b00};
            if (!diff[34])
            begin
                rem_reg <= diff[33:0];
                r_reg   <= {r_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial_rem;
                r_reg   <= {r_reg[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

[hdl/rolling_zscore_per_symbol.sv]
// rolling_zscore_per_symbol: per-symbol rolling window mean, deviation and z-score
// depends on rzs_pkg, rzs_ram, rzs_div, rzs_sqrt
//
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  cfg      | cfg_valid cfg_ready cfg_data[6:0]         | in
//  in       | in_valid in_ready symbol_index price      | in
//  out      | out_valid out_ready symbol_id window_mean | out
//           | std_deviation z_value flat_window         |
//
// one word at a time: table read, write, sum pass, mean divide, square pass,
// multiply/correct, var divide, sqrt and z divide run in turn before out_valid rises
// (a flat window skips the z divide); a word that gives no result stops after the
// write; the passes are bound by the one read port of the window ram and the
// bit-serial divider and root units.
// after reset or a window length write, a clear pass zeroes the position and fill
// tables of every symbol while in_ready stays low.
// a result waits in the output register; the next word is taken only after it leaves.
`timescale 1ns / 1ps
`default_nettype none
module rolling_zscore_per_symbol
    import rzs_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [rzs_pkg::LEN_W-1:0] cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [rzs_pkg::SYM_W-1:0] symbol_index,
    input  wire logic [rzs_pkg::PRICE_W-1:0] price,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [rzs_pkg::SYM_W-1:0]    symbol_id,
    output logic [rzs_pkg::PRICE_W-1:0]  window_mean,
    output logic [rzs_pkg::PRICE_W-1:0]  std_deviation,
    output logic signed [rzs_pkg::Z_W-1:0] z_value,
    output logic                         flat_window
);
    localparam int SW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int WW  = $clog2(WINDOW_MAX);
    localparam int LW  = $clog2(WINDOW_MAX + 1);
    localparam int AW  = SW + WW;
    localparam int SUMW = PRICE_W + LW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RDTAB, S_WRITE, S_SUM, S_MEAN, S_SQ, S_MUL,
        S_VDIV, S_SQRT, S_ZDIV, S_OUT
    } state_t;

    state_t state_reg;
    logic [LW-1:0]  len_reg;
    logic [SW-1:0]  clr_reg;
    logic [SW-1:0]  sym_reg;
    logic [PRICE_W-1:0] p_reg;
    logic [WW:0]    idx_reg;     // pass counter, one extra for ram latency
    logic [SUMW-1:0] sum_reg;
    logic [PRICE_W-1:0] mean_reg;
    logic [LW-1:0]  r_reg;
    logic [63:0]    acc_lo_reg;
    logic [LW+1:0]  acc_hi_reg;  // carries of the squared sum
    logic [95:0]    vnum_reg;
    logic [1:0]     mstep_reg;
    logic [PRICE_W-1:0] sd_reg;
    logic [PRICE_W-1:0] dabs_reg;
    logic           neg_reg;
    logic [PRICE_W-1:0] d_sq_reg;
    logic           sq_v_reg;
    logic           mean_done_q;

    // window ram
    logic           win_we;
    logic [AW-1:0]  win_waddr, win_raddr;
    logic [PRICE_W-1:0] win_rdata;
    // position and fill tables
    logic           tab_we;
    logic [SW-1:0]  tab_waddr, tab_raddr;
    logic [WW+LW-1:0] tab_wdata, tab_rdata;

    rzs_ram #(.WIDTH(PRICE_W), .DEPTH(1 << AW)) u_win (
        .clk(clk), .wr_en(win_we), .wr_addr(win_waddr), .wr_data(p_reg),
        .rd_addr(win_raddr), .rd_data(win_rdata)
    );

    rzs_ram #(.WIDTH(WW + LW), .DEPTH(1 << SW)) u_tab (
        .clk(clk), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
        .rd_addr(tab_raddr), .rd_data(tab_rdata)
    );

    logic [WW-1:0] pos_rd;
    logic [LW-1:0] fill_rd;
    logic [WW:0]   pos_use, pos_nx;
    logic [LW-1:0] fill_nx;
    assign pos_rd  = tab_rdata[WW+LW-1:LW];
    assign fill_rd = tab_rdata[LW-1:0];
    assign pos_use = ({1'b0, pos_rd} >= (WW+1)'(len_reg)) ? '0 : {1'b0, pos_rd};
    assign pos_nx  = ((pos_use + 1'b1) >= (WW+1)'(len_reg)) ? '0 : pos_use + 1'b1;
    assign fill_nx = (fill_rd < len_reg) ? fill_rd + 1'b1 : fill_rd;

    // table entry of the held symbol is read in S_RDTAB, used in S_WRITE
    assign tab_raddr = sym_reg;
    assign tab_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign tab_waddr = (state_reg == S_CLEAR) ? clr_reg : sym_reg;
    assign tab_wdata = (state_reg == S_CLEAR) ? '0 : {pos_nx[WW-1:0], fill_nx};

    assign win_we    = (state_reg == S_WRITE);
    assign win_waddr = {sym_reg, pos_use[WW-1:0]};
    assign win_raddr = {sym_reg, idx_reg[WW-1:0]};

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // |v - mean| of the word read this cycle
    logic [PRICE_W-1:0] dv;
    assign dv = (win_rdata >= mean_reg) ? win_rdata - mean_reg : mean_reg - win_rdata;

    // divider shared by variance and z
    logic          div_start, div_done;
    logic [95:0]   div_num, div_quo;
    logic [31:0]   div_den;
    logic          sqrt_start, sqrt_done;
    logic [31:0]   sqrt_root;
    rzs_var_req_t  vreq;

    assign vreq.num = vnum_reg;
    assign vreq.den = 21'(len_reg) * 21'(len_reg);
    assign div_num  = (state_reg == S_SQRT || state_reg == S_ZDIV) ?
                      {48'd0, dabs_reg, 16'd0} : vreq.num;
    assign div_den  = (state_reg == S_SQRT || state_reg == S_ZDIV) ?
                      sd_reg : 32'(vreq.den);

    rzs_div #(.NW(96), .DW(32)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    rzs_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start), .x(div_quo[63:0]),
        .done(sqrt_done), .root(sqrt_root)
    );

    logic [LW-1:0] cfg_len;
    assign cfg_len = (cfg_data == '0) ? LW'(1) :
                     (32'(cfg_data) > 32'(WINDOW_MAX)) ? LW'(WINDOW_MAX) : LW'(cfg_data);

    // multiply by small L in pieces: acc * L, then subtract r^2
    logic [95:0] acc96;
    logic [2*LW-1:0] rsq;
    assign acc96 = {{(32-LW-2){1'b0}}, acc_hi_reg, acc_lo_reg};
    assign rsq   = r_reg * r_reg;

    logic start_vdiv_q, start_z_q;
    assign div_start  = start_vdiv_q || start_z_q;
    assign sqrt_start = (state_reg == S_VDIV) && div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            len_reg      <= LW'(WINDOW_LENGTH_RESET > WINDOW_MAX ? WINDOW_MAX
                                                                 : WINDOW_LENGTH_RESET);
            clr_reg      <= '0;
            start_vdiv_q <= 1'b0;
            start_z_q    <= 1'b0;
            sq_v_reg     <= 1'b0;
        end
        else
        begin
            start_vdiv_q <= 1'b0;
            start_z_q    <= 1'b0;
            sq_v_reg     <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SW'(SYMBOL_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        len_reg   <= cfg_len;
                        clr_reg   <= '0;
                        state_reg <= S_CLEAR;
                    end
                    else if (in_valid && (32'(symbol_index) < 32'(SYMBOL_COUNT)))
                    begin
                        sym_reg   <= SW'(symbol_index);
                        p_reg     <= price;
                        state_reg <= S_RDTAB;
                    end
                end
                S_RDTAB:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    state_reg <= (fill_nx < len_reg) ? S_IDLE : S_SUM;
                end
                S_SUM:
                begin
                    // address idx issued, data for idx-1 arrives
                    if (idx_reg != '0)
                    begin
                        sum_reg <= sum_reg + SUMW'(win_rdata);
                    end
                    if (idx_reg == (WW+1)'(len_reg))
                    begin
                        state_reg <= S_MEAN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_MEAN:
                begin
                    // mean and remainder are ready; set up the square pass and z sign
                    if (mean_done_q)
                    begin
                        idx_reg    <= '0;
                        acc_lo_reg <= '0;
                        acc_hi_reg <= '0;
                        neg_reg    <= p_reg < mean_reg;
                        dabs_reg   <= (p_reg < mean_reg) ? mean_reg - p_reg : p_reg - mean_reg;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (idx_reg != '0)
                    begin
                        sq_v_reg <= 1'b1;
                        d_sq_reg <= dv;
                    end
                    if (sq_v_reg)
                    begin
                        {acc_hi_reg, acc_lo_reg} <= {acc_hi_reg, acc_lo_reg}
                            + (LW+66)'(64'(d_sq_reg) * 64'(d_sq_reg));
                    end
                    if (idx_reg == (WW+1)'(len_reg) + 1'b1)
                    begin
                        state_reg <= S_MUL;
                        mstep_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 1'b1;
                    case (mstep_reg)
                        2'd0: vnum_reg <= 96'(acc96[47:0] * 48'(len_reg));
                        2'd1: vnum_reg <= vnum_reg + {48'(acc96[95:48] * 48'(len_reg)), 48'd0};
                        2'd2:
                        begin
                            vnum_reg     <= vnum_reg - 96'(rsq);
                            start_vdiv_q <= 1'b1;
                            state_reg    <= S_VDIV;
                        end
                        default: vnum_reg <= vnum_reg;
                    endcase
                end
                S_VDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        sd_reg <= sqrt_root;
                        if (sqrt_root == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            start_z_q <= 1'b1;
                            state_reg <= S_ZDIV;
                        end
                    end
                end
                S_ZDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // mean divider: shift-subtract with a small remainder
    logic [5:0]      mcnt_reg;
    logic [LW:0]     mrem_reg;
    logic [SUMW-1:0] msum_reg;
    logic [LW:0]     mshift;
    logic [LW+1:0]   mdiff;
    logic            mean_busy_reg;
    logic            mean_start;
    assign mshift = {mrem_reg[LW-1:0], msum_reg[SUMW-1]};
    assign mdiff  = {1'b0, mshift} - {2'b0, len_reg};
    // one start per item: not again in the cycle that leaves S_MEAN
    assign mean_start = (state_reg == S_MEAN) && !mean_busy_reg && !mean_done_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_busy_reg <= 1'b0;
            mcnt_reg      <= '0;
        end
        else if (mean_start)
        begin
            mean_busy_reg <= 1'b1;
            mcnt_reg      <= 6'(SUMW);
        end
        else if (mean_busy_reg)
        begin
            mcnt_reg <= mcnt_reg - 1'b1;
            if (mcnt_reg == 6'd1)
            begin
                mean_busy_reg <= 1'b0;
            end
        end
    end

    logic mean_last;
    assign mean_last = mean_busy_reg && (mcnt_reg == 6'd1);

    always_ff @(posedge clk)
    begin
        if (mean_start)
        begin
            msum_reg <= sum_reg;
            mrem_reg <= '0;
        end
        else if (mean_busy_reg)
        begin
            if (!mdiff[LW+1])
            begin
                mrem_reg <= mdiff[LW:0];
                msum_reg <= {msum_reg[SUMW-2:0], 1'b1};
            end
            else
            begin
                mrem_reg <= mshift;
                msum_reg <= {msum_reg[SUMW-2:0], 1'b0};
            end
        end
        if (mean_last)
        begin
            if (!mdiff[LW+1])
            begin
                mean_reg <= {msum_reg[PRICE_W-2:0], 1'b1};
                r_reg    <= mdiff[LW-1:0];
            end
            else
            begin
                mean_reg <= {msum_reg[PRICE_W-2:0], 1'b0};
                r_reg    <= mshift[LW-1:0];
            end
        end
    end

    // mean_reg and r_reg are valid the cycle after the last divide step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_done_q <= 1'b0;
        end
        else
        begin
            mean_done_q <= mean_last;
        end
    end

    logic [PRICE_W-1:0] zmag;
    logic signed [Z_W-1:0] zsat;
    assign zmag = (div_quo[95:PRICE_W] != '0) ? '1 : div_quo[PRICE_W-1:0];
    always_comb
    begin
        if (neg_reg)
        begin
            zsat = (zmag > 32'd524288) ? -Z_W'(524288) : -Z_W'(zmag);
        end
        else
        begin
            zsat = (zmag > 32'd524287) ? Z_W'(524287) : Z_W'(zmag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SQRT && sqrt_done && sqrt_root == '0)
        begin
            z_value     <= '0;
            flat_window <= 1'b1;
        end
        else if (state_reg == S_ZDIV && div_done)
        begin
            z_value     <= zsat;
            flat_window <= 1'b0;
        end
        if (state_reg == S_SQRT && sqrt_done)
        begin
            std_deviation <= sqrt_root;
            window_mean   <= mean_reg;
            symbol_id     <= SYM_W'(sym_reg);
        end
    end

    // a word leaves only from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (len_reg != '0 && 32'(len_reg) <= WINDOW_MAX))
        else $error("window length out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && flat_window) |-> (std_deviation == '0 && z_value == '0))
        else $error("flat window with nonzero deviation");
endmodule
`default_nettype wire
